// ===== rtl/stdp_pkg.sv =====
// shared types, constants and kernel tables of the stdp weight update block
package stdp_pkg;

    // field widths
    localparam int KIND_W     = 2;
    localparam int TIME_W     = 32;
    localparam int AMP_W      = 18;
    localparam int WEIGHT_W   = 25;
    localparam int DEV_W      = 32;
    localparam int DECAY_W    = 17;
    localparam int ENTRY_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // kernel window and time constants in steps
    localparam int KERNEL_DEPTH  = 256;
    localparam int TAU_POT_STEPS = 20;
    localparam int TAU_DEP_STEPS = 20;
    localparam int IDX_W         = $clog2(KERNEL_DEPTH);

    // rounded amp * entry fits in amp width plus one
    localparam int CONTRIB_W = AMP_W + 1;

    // op queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // event kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PRE  = 2'd0,
        KIND_POST = 2'd1,
        KIND_TICK = 2'd2
    } t_kind;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LTP_AMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LTD_AMP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 3'd4;

    typedef struct packed {
        logic signed [AMP_W-1:0]    ltp_amp;
        logic signed [AMP_W-1:0]    ltd_amp;
        logic        [WEIGHT_W-1:0] weight_max;
        logic signed [AMP_W-1:0]    drift;
        logic        [DECAY_W-1:0]  decay;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ltp_amp:    18'sd6554,
        ltd_amp:    -18'sd7864,
        weight_max: 25'd655360,
        drift:      18'sd6554,
        decay:      17'd24109
    };

    // state reset values
    localparam logic signed [TIME_W-1:0] LAST_PRE_RESET  = -32'sd10000;
    localparam logic signed [TIME_W-1:0] LAST_POST_RESET = 32'sd0;
    localparam logic [WEIGHT_W-1:0]      WEIGHT_RESET    = 25'd65536;

    // one op handed from front to back
    typedef struct packed {
        logic                        tick;
        logic signed [CONTRIB_W-1:0] contrib;
    } t_op;

    // saturate a wide signed value to the deviation range
    localparam logic signed [DEV_W+1:0] SAT_HI = $signed({3'b000, {(DEV_W-1){1'b1}}});
    localparam logic signed [DEV_W+1:0] SAT_LO = $signed({3'b111, {(DEV_W-1){1'b0}}});

    function automatic logic signed [DEV_W-1:0] sat_dev(input logic signed [DEV_W+1:0] v);
        logic signed [DEV_W-1:0] r;
        if (v > SAT_HI) begin
            r = $signed({1'b0, {(DEV_W-1){1'b1}}});
        end else if (v < SAT_LO) begin
            r = $signed({1'b1, {(DEV_W-1){1'b0}}});
        end else begin
            r = v[DEV_W-1:0];
        end
        return r;
    endfunction

    // exp(-1/tau) in Q40 as a truncated taylor series, potentiation side
    localparam longint PT00 = 64'sd1 <<< 40;
    localparam longint PT01 = PT00 / (1 * TAU_POT_STEPS);
    localparam longint PT02 = PT01 / (2 * TAU_POT_STEPS);
    localparam longint PT03 = PT02 / (3 * TAU_POT_STEPS);
    localparam longint PT04 = PT03 / (4 * TAU_POT_STEPS);
    localparam longint PT05 = PT04 / (5 * TAU_POT_STEPS);
    localparam longint PT06 = PT05 / (6 * TAU_POT_STEPS);
    localparam longint PT07 = PT06 / (7 * TAU_POT_STEPS);
    localparam longint PT08 = PT07 / (8 * TAU_POT_STEPS);
    localparam longint PT09 = PT08 / (9 * TAU_POT_STEPS);
    localparam longint PT10 = PT09 / (10 * TAU_POT_STEPS);
    localparam longint PT11 = PT10 / (11 * TAU_POT_STEPS);
    localparam longint PT12 = PT11 / (12 * TAU_POT_STEPS);
    localparam longint PT13 = PT12 / (13 * TAU_POT_STEPS);
    localparam longint PT14 = PT13 / (14 * TAU_POT_STEPS);
    localparam longint PT15 = PT14 / (15 * TAU_POT_STEPS);
    localparam longint PT16 = PT15 / (16 * TAU_POT_STEPS);
    localparam longint PT17 = PT16 / (17 * TAU_POT_STEPS);
    localparam longint PT18 = PT17 / (18 * TAU_POT_STEPS);
    localparam longint PT19 = PT18 / (19 * TAU_POT_STEPS);
    localparam longint PT20 = PT19 / (20 * TAU_POT_STEPS);
    localparam longint PT21 = PT20 / (21 * TAU_POT_STEPS);
    localparam longint PT22 = PT21 / (22 * TAU_POT_STEPS);
    localparam longint PT23 = PT22 / (23 * TAU_POT_STEPS);
    localparam longint PT24 = PT23 / (24 * TAU_POT_STEPS);
    localparam longint PS_POT = PT00 - PT01 + PT02 - PT03 + PT04 - PT05 + PT06 - PT07
                              + PT08 - PT09 + PT10 - PT11 + PT12 - PT13 + PT14 - PT15
                              + PT16 - PT17 + PT18 - PT19 + PT20 - PT21 + PT22 - PT23
                              + PT24;
    localparam longint R_POT = ((PS_POT < 0 ? 64'sd0 : PS_POT) + 64'sd512) >>> 10;

    // same series, depression side
    localparam longint DT00 = 64'sd1 <<< 40;
    localparam longint DT01 = DT00 / (1 * TAU_DEP_STEPS);
    localparam longint DT02 = DT01 / (2 * TAU_DEP_STEPS);
    localparam longint DT03 = DT02 / (3 * TAU_DEP_STEPS);
    localparam longint DT04 = DT03 / (4 * TAU_DEP_STEPS);
    localparam longint DT05 = DT04 / (5 * TAU_DEP_STEPS);
    localparam longint DT06 = DT05 / (6 * TAU_DEP_STEPS);
    localparam longint DT07 = DT06 / (7 * TAU_DEP_STEPS);
    localparam longint DT08 = DT07 / (8 * TAU_DEP_STEPS);
    localparam longint DT09 = DT08 / (9 * TAU_DEP_STEPS);
    localparam longint DT10 = DT09 / (10 * TAU_DEP_STEPS);
    localparam longint DT11 = DT10 / (11 * TAU_DEP_STEPS);
    localparam longint DT12 = DT11 / (12 * TAU_DEP_STEPS);
    localparam longint DT13 = DT12 / (13 * TAU_DEP_STEPS);
    localparam longint DT14 = DT13 / (14 * TAU_DEP_STEPS);
    localparam longint DT15 = DT14 / (15 * TAU_DEP_STEPS);
    localparam longint DT16 = DT15 / (16 * TAU_DEP_STEPS);
    localparam longint DT17 = DT16 / (17 * TAU_DEP_STEPS);
    localparam longint DT18 = DT17 / (18 * TAU_DEP_STEPS);
    localparam longint DT19 = DT18 / (19 * TAU_DEP_STEPS);
    localparam longint DT20 = DT19 / (20 * TAU_DEP_STEPS);
    localparam longint DT21 = DT20 / (21 * TAU_DEP_STEPS);
    localparam longint DT22 = DT21 / (22 * TAU_DEP_STEPS);
    localparam longint DT23 = DT22 / (23 * TAU_DEP_STEPS);
    localparam longint DT24 = DT23 / (24 * TAU_DEP_STEPS);
    localparam longint PS_DEP = DT00 - DT01 + DT02 - DT03 + DT04 - DT05 + DT06 - DT07
                              + DT08 - DT09 + DT10 - DT11 + DT12 - DT13 + DT14 - DT15
                              + DT16 - DT17 + DT18 - DT19 + DT20 - DT21 + DT22 - DT23
                              + DT24;
    localparam longint R_DEP = ((PS_DEP < 0 ? 64'sd0 : PS_DEP) + 64'sd512) >>> 10;

    typedef logic [ENTRY_W-1:0] t_kernel [KERNEL_DEPTH];

    // entry k = exp(-k/tau) in q0.16, built by repeated q30 multiplication
    function automatic t_kernel build_kernel(input longint r);
        t_kernel          tab;
        longint unsigned  v;
        longint unsigned  rr;
        longint unsigned  e;
        v  = 64'd1 << 30;
        rr = $unsigned(r);
        for (int k = 0; k < KERNEL_DEPTH; k++) begin
            if (k > 0) begin
                v = (v * rr + (64'd1 << 29)) >> 30;
            end
            e = (v + (64'd1 << 13)) >> 14;
            tab[k] = (e > 64'd65535) ? {ENTRY_W{1'b1}} : e[ENTRY_W-1:0];
        end
        return tab;
    endfunction

    localparam t_kernel POT_TABLE = build_kernel(R_POT);
    localparam t_kernel DEP_TABLE = build_kernel(R_DEP);

endpackage

// ===== rtl/stdp_if.sv =====
// valid/ready channel interfaces for spike events and weight results
interface stdp_evt_if import stdp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [TIME_W-1:0] event_time;

    modport source (output valid, output kind, output event_time, input ready);
    modport sink   (input valid, input kind, input event_time, output ready);
endinterface

interface stdp_res_if import stdp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [WEIGHT_W-1:0]      weight_out;
    logic signed [DEV_W-1:0]  deviation_out;

    modport source (output valid, output weight_out, output deviation_out, input ready);
    modport sink   (input valid, input weight_out, input deviation_out, output ready);
endinterface

// ===== rtl/stdp_queue.sv =====
// short op queue between the classify front and the update back
module stdp_queue import stdp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_op               i_op,
    input  logic              i_pop,
    output t_op               o_op,
    output logic [QCNT_W-1:0] o_count
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    assign o_op    = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== rtl/stdp_front.sv =====
// front: accepts events, tracks spike times, looks up the kernel and scales it
module stdp_front import stdp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stdp_evt_if.sink          i_evt,
    input  t_cfg              i_cfg,
    input  logic [QCNT_W-1:0] i_q_count,
    output logic              o_push,
    output t_op               o_op
);

    localparam logic signed [TIME_W+1:0] DEPTH_S = (TIME_W+2)'(KERNEL_DEPTH);

    logic signed [TIME_W-1:0] r_last_pre;
    logic signed [TIME_W-1:0] r_last_post;

    logic                     r_f1_valid;
    logic                     r_f1_tick;
    logic                     r_f1_live;
    logic [ENTRY_W-1:0]       r_f1_entry;
    logic signed [AMP_W-1:0]  r_f1_amp;

    logic                     n_tick;
    logic                     n_live;
    logic [ENTRY_W-1:0]       n_entry;
    logic signed [AMP_W-1:0]  n_amp;

    logic                     w_accept;
    logic signed [TIME_W+1:0] w_diff_dep;
    logic signed [TIME_W+1:0] w_diff_pot;
    logic [IDX_W-1:0]         w_idx_dep;
    logic [IDX_W-1:0]         w_idx_pot;
    logic [QCNT_W:0]          w_used;

    logic signed [AMP_W+ENTRY_W:0] w_prod;
    logic signed [AMP_W+ENTRY_W:0] w_prod_rnd;

    // every item in flight already has a queue slot reserved
    assign w_used      = (QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(r_f1_valid);
    assign i_evt.ready = w_used < (QCNT_W+1)'(QUEUE_DEPTH);
    assign w_accept    = i_evt.valid && i_evt.ready;

    assign w_diff_dep = (TIME_W+2)'(i_evt.event_time) - (TIME_W+2)'(r_last_post)
                      - (TIME_W+2)'(1);
    assign w_diff_pot = (TIME_W+2)'(i_evt.event_time) - (TIME_W+2)'(r_last_pre);

    // negative gaps fold onto the first entry
    assign w_idx_dep = (w_diff_dep < 0) ? '0 : w_diff_dep[IDX_W-1:0];
    assign w_idx_pot = (w_diff_pot < 0) ? '0 : w_diff_pot[IDX_W-1:0];

    always_comb begin
        n_tick  = 1'b0;
        n_live  = 1'b0;
        n_entry = '0;
        n_amp   = '0;
        unique case (i_evt.kind)
            KIND_PRE: begin
                n_live  = w_diff_dep < DEPTH_S;
                n_entry = DEP_TABLE[w_idx_dep];
                n_amp   = i_cfg.ltd_amp;
            end
            KIND_POST: begin
                n_live  = w_diff_pot < DEPTH_S;
                n_entry = POT_TABLE[w_idx_pot];
                n_amp   = i_cfg.ltp_amp;
            end
            KIND_TICK: begin
                n_tick = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid  <= 1'b0;
            r_last_pre  <= LAST_PRE_RESET;
            r_last_post <= LAST_POST_RESET;
        end else begin
            r_f1_valid <= w_accept;
            if (w_accept && i_evt.kind == KIND_PRE) begin
                r_last_pre <= i_evt.event_time;
            end
            if (w_accept && i_evt.kind == KIND_POST) begin
                r_last_post <= i_evt.event_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_tick  <= n_tick;
            r_f1_live  <= n_live;
            r_f1_entry <= n_entry;
            r_f1_amp   <= n_amp;
        end
    end

    // amp * entry, rounded half up by 16 bits
    assign w_prod     = r_f1_amp * $signed({1'b0, r_f1_entry});
    assign w_prod_rnd = w_prod + (AMP_W+ENTRY_W+1)'(1 << 15);

    assign o_push       = r_f1_valid;
    assign o_op.tick    = r_f1_tick;
    assign o_op.contrib = r_f1_live ? w_prod_rnd[AMP_W+ENTRY_W:16] : '0;

endmodule

// ===== rtl/stdp_back.sv =====
// back: applies ops to the deviation, then on a tick updates and clamps the weight
module stdp_back import stdp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_op               i_op,
    input  logic [QCNT_W-1:0] i_q_count,
    output logic              o_pop,
    stdp_res_if.source        o_res
);

    logic signed [DEV_W-1:0]    r_dev;
    logic [WEIGHT_W-1:0]        r_weight;

    logic                       r_b1_valid;
    logic                       r_b1_tick;
    logic signed [DEV_W-1:0]    r_b1_dev;

    logic                       r_out_valid;
    logic signed [DEV_W-1:0]    r_out_dev;

    logic                       w_b1_load;
    logic                       w_b2_load;
    logic signed [DEV_W+DECAY_W:0] w_decay_prod;
    logic signed [DEV_W+DECAY_W:0] w_decay_rnd;
    logic signed [DEV_W+1:0]    w_spike_sum;
    logic signed [DEV_W-1:0]    n_dev;
    logic signed [DEV_W+1:0]    w_wsum;
    logic [WEIGHT_W-1:0]        n_weight;

    assign w_b2_load = r_b1_valid && (!r_out_valid || o_res.ready);
    assign w_b1_load = (i_q_count != '0) && (!r_b1_valid || w_b2_load);
    assign o_pop     = w_b1_load;

    // deviation step: decay on a tick, saturating add on a spike
    assign w_decay_prod = r_dev * $signed({1'b0, i_cfg.decay});
    assign w_decay_rnd  = w_decay_prod + (DEV_W+DECAY_W+1)'(1 << 15);
    assign w_spike_sum  = (DEV_W+2)'(r_dev) + (DEV_W+2)'(i_op.contrib);

    always_comb begin
        if (i_op.tick) begin
            n_dev = sat_dev(w_decay_rnd[DEV_W+DECAY_W:16]);
        end else begin
            n_dev = sat_dev(w_spike_sum);
        end
    end

    // weight step: add drift and deviation, clamp to max first, then to zero
    assign w_wsum = $signed((DEV_W+2)'(r_weight)) + (DEV_W+2)'(i_cfg.drift)
                  + (DEV_W+2)'(r_b1_dev);

    always_comb begin
        if (w_wsum > $signed((DEV_W+2)'(i_cfg.weight_max))) begin
            n_weight = i_cfg.weight_max;
        end else if (w_wsum < 0) begin
            n_weight = '0;
        end else begin
            n_weight = w_wsum[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev       <= '0;
            r_weight    <= WEIGHT_RESET;
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_b1_load) begin
                r_dev <= n_dev;
            end
            if (w_b1_load) begin
                r_b1_valid <= 1'b1;
            end else if (w_b2_load) begin
                r_b1_valid <= 1'b0;
            end
            if (w_b2_load) begin
                r_out_valid <= 1'b1;
                if (r_b1_tick) begin
                    r_weight <= n_weight;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b1_load) begin
            r_b1_tick <= i_op.tick;
            r_b1_dev  <= n_dev;
        end
        if (w_b2_load) begin
            r_out_dev <= r_b1_dev;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.weight_out    = r_weight;
    assign o_res.deviation_out = r_out_dev;

endmodule

// ===== rtl/stdp_weight_update_top.sv =====
// top level of the stdp weight update engine for one synapse
// an item passes the front register, the op queue, the deviation register and the result register
// throughput: one item per cycle unless the output stalls, set by the deviation loop (one 32x18 multiply and saturate)
// a 4-entry op queue lets the front keep accepting while the result side stalls
// reset: synchronous active low; kernel tables are constants, no clearing pass
// after reset the registers hold their defaults and the weight is 1.0 in q16
module stdp_weight_update_top import stdp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    stdp_evt_if.sink              i_evt,
    stdp_res_if.source            o_res
);

    // configuration registers, to be written by the user only while the block is idle; the block does not enforce it
    t_cfg r_cfg;

    // front to queue
    logic              w_push;
    t_op               w_push_op;

    // queue to back
    logic              w_pop;
    t_op               w_head_op;
    logic [QCNT_W-1:0] w_q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LTP_AMP:    r_cfg.ltp_amp    <= $signed(i_cfg_data[AMP_W-1:0]);
                CFG_LTD_AMP:    r_cfg.ltd_amp    <= $signed(i_cfg_data[AMP_W-1:0]);
                CFG_WEIGHT_MAX: r_cfg.weight_max <= i_cfg_data[WEIGHT_W-1:0];
                CFG_DRIFT:      r_cfg.drift      <= $signed(i_cfg_data[AMP_W-1:0]);
                CFG_DECAY:      r_cfg.decay      <= i_cfg_data[DECAY_W-1:0];
                // unused indexes are dropped
                default: begin
                end
            endcase
        end
    end

    // front: spike time bookkeeping, kernel lookup and amplitude multiply
    stdp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_evt     (i_evt),
        .i_cfg     (r_cfg),
        .i_q_count (w_q_count),
        .o_push    (w_push),
        .o_op      (w_push_op)
    );

    // queue: decouples classification from the state update
    stdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_count (w_q_count)
    );

    // back: deviation update stage, then weight update and result register
    stdp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_op      (w_head_op),
        .i_q_count (w_q_count),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

// ===== rtl/stdp_chk.sv =====
// port level checks for the stdp weight update engine, bound to the top level
module stdp_chk import stdp_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_evt_ready,
    input logic                    i_res_valid,
    input logic                    i_res_ready,
    input logic [WEIGHT_W-1:0]     i_weight,
    input logic signed [DEV_W-1:0] i_dev
);

    // a stalled result holds its item
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_weight) && $stable(i_dev))
        else $error("result changed while stalled");

    // after reset no result is valid and the input is ready
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid && i_evt_ready)
        else $error("block not empty after reset");

    // the queue only fills up behind a waiting result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_evt_ready |-> i_res_valid)
        else $error("input stalled with no result waiting");

    // input stall only ever comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_evt_ready) |-> $past(i_res_valid && !i_res_ready))
        else $error("input stalled without output backpressure");

endmodule

bind stdp_weight_update_top stdp_chk u_stdp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_evt_ready (i_evt.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_weight    (o_res.weight_out),
    .i_dev       (o_res.deviation_out)
);
